// ----- src/dcfl_pkg.sv -----
package dcfl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = 8;
   localparam int CNT_W       = 9;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // chain flag bits: bit 0 next, bit 1 device writes
   localparam int FLAG_NEXT_BIT = 0;
   localparam logic [1:0] FLAGS_NEXT       = 2'b01;
   localparam logic [1:0] FLAGS_WRITE      = 2'b10;
   localparam logic [1:0] FLAGS_NEXT_WRITE = 2'b11;

   localparam logic [1:0] FREED_MAX = 2'd3;
   localparam logic [CNT_W-1:0] NEED_BASE = 9'd2;

   typedef struct packed {
      logic             action;
      logic             has_data;
      logic             device_writes_data;
      logic [IDX_W-1:0] release_head;
   } req_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] head_index;
      logic [IDX_W-1:0] data_index;
      logic [IDX_W-1:0] status_index;
      logic [CNT_W-1:0] free_count;
      logic [1:0]       freed_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       flags;
      logic [IDX_W-1:0] link;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

// ----- src/dcfl_mem.sv -----
module dcfl_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  dcfl_pkg::mem_req_type mem_req,
   output dcfl_pkg::entry_type   rd_data
);

   dcfl_pkg::entry_type mem_ff [dcfl_pkg::TABLE_DEPTH];
   dcfl_pkg::entry_type mem_q_ff;
   dcfl_pkg::entry_type fwd_data_ff;
   logic [dcfl_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic                             rd_valid_ff;
   logic                             fwd_ff;
   logic [dcfl_pkg::IDX_W-1:0]       rd_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         mem_q_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   // entries never written read as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   // same-cycle write to the entry being read is forwarded
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_addr_ff  <= mem_req.rd_addr;
         rd_valid_ff <= valid_ff[mem_req.rd_addr];
         fwd_ff      <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
         fwd_data_ff <= mem_req.wr_data;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data.flags = 2'b00;
         rd_data.link  = rd_addr_ff - 8'd1;
      end
   end

endmodule

// ----- src/dcfl_walk.sv -----
module dcfl_walk #(
   parameter int QUEUE_SIZE = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dcfl_pkg::req_type     req_data,
   output dcfl_pkg::mem_req_type mem_req,
   input  dcfl_pkg::entry_type   mem_rd_data,
   output logic                  done_valid,
   input  logic                  done_ready,
   output dcfl_pkg::rsp_type     done_data
);

   localparam logic [dcfl_pkg::CNT_W-1:0] QS_CNT   = 9'(QUEUE_SIZE);
   localparam logic [dcfl_pkg::IDX_W-1:0] HEAD_RST = 8'(QUEUE_SIZE - 1);

   dcfl_pkg::state_type state_ff, state_in;
   dcfl_pkg::req_type   item_ff, item_in;
   dcfl_pkg::rsp_type   rsp_ff, rsp_in;
   logic [dcfl_pkg::IDX_W-1:0] cur_ff, cur_in;
   logic [dcfl_pkg::IDX_W-1:0] free_head_ff, free_head_in;
   logic [dcfl_pkg::CNT_W-1:0] free_total_ff, free_total_in;
   logic [1:0]                 pos_ff, pos_in;

   logic                       accept;
   logic                       in_is_rel;
   logic                       in_need_ok;
   logic                       in_rel_ok;
   logic                       start_walk;
   logic                       item_is_rel;
   logic                       alloc_last;
   logic                       rel_stop;
   logic                       walk_end;
   logic [dcfl_pkg::CNT_W-1:0] in_need;
   logic [dcfl_pkg::CNT_W-1:0] item_need;
   logic [dcfl_pkg::CNT_W-1:0] total_inc;
   logic [1:0]                 last_pos;
   logic [1:0]                 pos_next;
   logic [1:0]                 alloc_flags;

   assign accept      = req_valid && (state_ff == dcfl_pkg::ST_IDLE);
   assign in_is_rel   = req_data.action == dcfl_pkg::ACT_RELEASE;
   assign in_need     = dcfl_pkg::NEED_BASE + 9'(req_data.has_data);
   assign in_need_ok  = free_total_ff >= in_need;
   assign in_rel_ok   = {1'b0, req_data.release_head} < QS_CNT;
   assign start_walk  = accept && (in_is_rel ? in_rel_ok : in_need_ok);

   assign item_is_rel = item_ff.action == dcfl_pkg::ACT_RELEASE;
   assign item_need   = dcfl_pkg::NEED_BASE + 9'(item_ff.has_data);
   assign last_pos    = item_ff.has_data ? 2'd2 : 2'd1;
   assign alloc_last  = pos_ff == last_pos;
   assign pos_next    = pos_ff + 2'd1;
   assign rel_stop    = !mem_rd_data.flags[dcfl_pkg::FLAG_NEXT_BIT]
                        || (pos_next == dcfl_pkg::FREED_MAX)
                        || ({1'b0, mem_rd_data.link} >= QS_CNT);
   assign walk_end    = item_is_rel ? rel_stop : alloc_last;
   assign total_inc   = (free_total_ff < QS_CNT) ? free_total_ff + 9'd1 : free_total_ff;

   always_comb begin
      if (pos_ff == 2'd0) begin
         alloc_flags = dcfl_pkg::FLAGS_NEXT;
      end else if (alloc_last) begin
         alloc_flags = dcfl_pkg::FLAGS_WRITE;
      end else if (item_ff.device_writes_data) begin
         alloc_flags = dcfl_pkg::FLAGS_NEXT_WRITE;
      end else begin
         alloc_flags = dcfl_pkg::FLAGS_NEXT;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcfl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = start_walk ? dcfl_pkg::ST_WALK : dcfl_pkg::ST_DONE;
            end
         end
         dcfl_pkg::ST_WALK: begin
            if (walk_end) begin
               state_in = dcfl_pkg::ST_DONE;
            end
         end
         dcfl_pkg::ST_DONE: begin
            if (done_ready) begin
               state_in = dcfl_pkg::ST_IDLE;
            end
         end
         default: state_in = dcfl_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = state_ff == dcfl_pkg::ST_IDLE;
      done_valid = state_ff == dcfl_pkg::ST_DONE;
      done_data  = rsp_ff;
      mem_req    = '0;
      unique case (state_ff)
         dcfl_pkg::ST_IDLE: begin
            mem_req.rd_en   = start_walk;
            mem_req.rd_addr = in_is_rel ? req_data.release_head : free_head_ff;
         end
         dcfl_pkg::ST_WALK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            if (item_is_rel) begin
               // push: link to old top, keep flags
               mem_req.wr_data.flags = mem_rd_data.flags;
               mem_req.wr_data.link  = free_head_ff;
            end else begin
               mem_req.wr_data.flags = alloc_flags;
               mem_req.wr_data.link  = mem_rd_data.link;
            end
            mem_req.rd_en   = !walk_end;
            mem_req.rd_addr = mem_rd_data.link;
         end
         dcfl_pkg::ST_DONE: begin
            mem_req = '0;
         end
         default: mem_req = '0;
      endcase
   end

   // datapath next values
   always_comb begin
      item_in       = item_ff;
      rsp_in        = rsp_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      free_head_in  = free_head_ff;
      free_total_in = free_total_ff;
      if (accept) begin
         item_in           = req_data;
         pos_in            = 2'd0;
         rsp_in            = '0;
         rsp_in.free_count = free_total_ff;
         if (in_is_rel) begin
            rsp_in.head_index = req_data.release_head;
            cur_in            = req_data.release_head;
         end else begin
            cur_in = free_head_ff;
         end
      end else if (state_ff == dcfl_pkg::ST_WALK) begin
         cur_in = mem_rd_data.link;
         pos_in = pos_next;
         if (item_is_rel) begin
            free_head_in       = cur_ff;
            free_total_in      = total_inc;
            rsp_in.freed_count = pos_next;
            rsp_in.free_count  = total_inc;
         end else begin
            if (pos_ff == 2'd0) begin
               rsp_in.head_index = cur_ff;
            end else if (!alloc_last) begin
               rsp_in.data_index = cur_ff;
            end
            if (alloc_last) begin
               rsp_in.status_index = cur_ff;
               rsp_in.granted      = 1'b1;
               free_head_in        = mem_rd_data.link;
               free_total_in       = free_total_ff - item_need;
               rsp_in.free_count   = free_total_ff - item_need;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dcfl_pkg::ST_IDLE;
         free_head_ff  <= HEAD_RST;
         free_total_ff <= QS_CNT;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_total_ff <= free_total_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      cur_ff  <= cur_in;
      pos_ff  <= pos_in;
   end

endmodule

// ----- src/dcfl_obuf.sv -----
module dcfl_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dcfl_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dcfl_pkg::rsp_type out_data
);

   logic              valid_ff, valid_in;
   dcfl_pkg::rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ----- src/descriptor_chain_free_list.sv -----
// Descriptor chain free list.
// req_ channel: one word per item. action selects allocate (pop a chain of
// two descriptors, or three with has_data) or release (walk a used chain
// from release_head and push each entry back, at most three).
// rsp_ channel: exactly one word per item: granted, chain indices, free
// count after the item and, for a release, the number freed.
// One item is in work at a time. Each descriptor visited is one pass of
// the descriptor table's read-modify-write loop (registered read, with
// same-entry forwarding). A refused allocate or an out-of-range release
// head visits no descriptor; the item goes straight to its response word.
// Results sit in an output register; while rsp_ready is low the block
// still takes and finishes one more item, then holds it until the register
// frees. Reset (synchronous) makes the whole queue free; table entries not
// yet written read as their reset value, so no clearing pass is needed.
module descriptor_chain_free_list #(
   parameter int QUEUE_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dcfl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dcfl_pkg::rsp_type rsp_data
);

   dcfl_pkg::mem_req_type mem_req;
   dcfl_pkg::entry_type   mem_rd_data;
   logic                  done_valid;
   logic                  done_ready;
   dcfl_pkg::rsp_type     done_data;

   dcfl_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   dcfl_walk #(
      .QUEUE_SIZE (QUEUE_SIZE)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data)
   );

   dcfl_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (done_valid),
      .in_ready  (done_ready),
      .in_data   (done_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
